// File: hdl/pnm_pkg.sv
// Shared types, constants and character helpers for the ASCII PNM sample parser.
package pnm_pkg;

  localparam int WORD_BUFFER_BYTES = 8;
  localparam int DIMENSION_BITS    = 16;
  localparam int WORD_MAX_LEN      = WORD_BUFFER_BYTES - 1;
  localparam int LEN_W             = $clog2(WORD_BUFFER_BYTES);
  localparam int NUM_W             = 20;
  localparam int SCALE_W           = 32;
  localparam int SAMPLE_W          = 16;
  localparam int CH_W              = 3;
  localparam int CH_IDX_W          = 2;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 32;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_SAMPLES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_SCALE   = 3'd4;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_NUMERIC = 2'd1,
    ST_TOO_LONG    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_SKIP    = 2'd0,
    PH_WORD    = 2'd1,
    PH_COMMENT = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       stream_end;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_value;
    logic                frame_last;
    status_t             parse_status;
  } out_t;

  typedef struct packed {
    logic [DIMENSION_BITS-1:0] frame_width;
    logic [DIMENSION_BITS-1:0] frame_height;
    logic [CH_W-1:0]           channel_count;
    logic                      wide_samples;
    logic [SCALE_W-1:0]        range_scale;
  } cfg_t;

  typedef struct packed {
    logic             close;
    status_t          status;
    logic [NUM_W-1:0] number;
  } close_evt_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alnum(input logic [7:0] b);
    return is_digit(b) || ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
  endfunction

endpackage

// File: hdl/pnm_scan.sv
// Byte scanner: separator/comment skipping, word collection and sticky error latch.
module pnm_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  pnm_pkg::in_t        in_beat,
  output pnm_pkg::close_evt_t evt
);

  pnm_pkg::phase_t                phase_r, phase_nxt, mid_phase;
  logic [pnm_pkg::LEN_W-1:0]      len_r, len_nxt, base_len, post_len;
  logic [pnm_pkg::NUM_W-1:0]      num_r, num_nxt, base_num, post_num;
  logic                           lead_r, lead_nxt, base_lead, post_lead;
  logic                           closed_r, closed_nxt, base_closed, post_closed;
  logic                           err_r, err_nxt;
  logic                           step_en, alnum, digit, append, close;
  logic [pnm_pkg::NUM_W+4:0]      num_ext;
  pnm_pkg::status_t               status;

  assign step_en = step && !err_r;
  assign alnum   = pnm_pkg::is_alnum(in_beat.text_byte);
  assign digit   = pnm_pkg::is_digit(in_beat.text_byte);
  assign append  = ((phase_r == pnm_pkg::PH_SKIP) && alnum) ||
                   ((phase_r == pnm_pkg::PH_WORD) &&
                    (alnum || (in_beat.text_byte == pnm_pkg::CH_UNDER)));

  // word datapath: append the current byte onto the open (or fresh) word
  always_comb begin
    if (phase_r == pnm_pkg::PH_SKIP) begin
      base_len    = '0;
      base_num    = '0;
      base_lead   = 1'b0;
      base_closed = 1'b0;
    end else begin
      base_len    = len_r;
      base_num    = num_r;
      base_lead   = lead_r;
      base_closed = closed_r;
    end
    num_ext = {2'b00, base_num, 3'b000} + {4'b0000, base_num, 1'b0} +
              {{(pnm_pkg::NUM_W+1){1'b0}}, in_beat.text_byte[3:0]};
    post_len    = base_len;
    post_num    = base_num;
    post_lead   = base_lead;
    post_closed = base_closed;
    if (append) begin
      if (base_len == '0) begin
        post_lead = digit;
      end
      if (digit && !base_closed) begin
        post_num = (|num_ext[pnm_pkg::NUM_W+4:pnm_pkg::NUM_W]) ? '1 :
                   num_ext[pnm_pkg::NUM_W-1:0];
      end else if (!digit) begin
        post_closed = 1'b1;
      end
      if (base_len < pnm_pkg::LEN_W'(pnm_pkg::WORD_MAX_LEN)) begin
        post_len = base_len + 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    mid_phase = phase_r;
    case (phase_r)
      pnm_pkg::PH_SKIP: begin
        if (alnum) begin
          mid_phase = pnm_pkg::PH_WORD;
        end else if (in_beat.text_byte == pnm_pkg::CH_HASH) begin
          mid_phase = pnm_pkg::PH_COMMENT;
        end
      end
      pnm_pkg::PH_WORD: begin
        if (!append) begin
          mid_phase = (in_beat.text_byte == pnm_pkg::CH_HASH) ? pnm_pkg::PH_COMMENT :
                      pnm_pkg::PH_SKIP;
        end
      end
      pnm_pkg::PH_COMMENT: begin
        if (in_beat.text_byte == pnm_pkg::CH_NL) begin
          mid_phase = pnm_pkg::PH_SKIP;
        end
      end
      default: mid_phase = pnm_pkg::PH_SKIP;
    endcase
    phase_nxt  = in_beat.stream_end ? pnm_pkg::PH_SKIP : mid_phase;
    len_nxt    = append ? post_len : len_r;
    num_nxt    = append ? post_num : num_r;
    lead_nxt   = append ? post_lead : lead_r;
    closed_nxt = append ? post_closed : closed_r;
    err_nxt    = err_r || (step_en && close && (status != pnm_pkg::ST_OK));
  end

  // outputs
  always_comb begin
    close = ((phase_r == pnm_pkg::PH_WORD) && !append) ||
            (in_beat.stream_end && (mid_phase == pnm_pkg::PH_WORD));
    if (post_len >= pnm_pkg::LEN_W'(pnm_pkg::WORD_MAX_LEN)) begin
      status = pnm_pkg::ST_TOO_LONG;
    end else if (!post_lead) begin
      status = pnm_pkg::ST_NOT_NUMERIC;
    end else begin
      status = pnm_pkg::ST_OK;
    end
    evt.close  = step_en && close;
    evt.status = status;
    evt.number = post_num;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= pnm_pkg::PH_SKIP;
      len_r    <= '0;
      num_r    <= '0;
      lead_r   <= 1'b0;
      closed_r <= 1'b0;
      err_r    <= 1'b0;
    end else begin
      err_r <= err_nxt;
      if (step_en) begin
        phase_r  <= phase_nxt;
        len_r    <= len_nxt;
        num_r    <= num_nxt;
        lead_r   <= lead_nxt;
        closed_r <= closed_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |=> err_r)
    else $error("error latch dropped without reset");

  a_err_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(err_r) |-> $past(evt.close && (evt.status != pnm_pkg::ST_OK)))
    else $error("error latched without an error word");
`endif

endmodule

// File: hdl/pnm_scale.sv
// Sample scaling: word value times Q16.16 factor, fraction dropped, saturated to 8 or 16 bits.
module pnm_scale (
  input  logic [pnm_pkg::NUM_W-1:0]    number,
  input  pnm_pkg::cfg_t                cfg,
  output logic [pnm_pkg::SAMPLE_W-1:0] sample
);

  localparam int PROD_W = pnm_pkg::NUM_W + pnm_pkg::SCALE_W;

  logic [PROD_W-1:0]    prod;
  logic [PROD_W-17:0]   whole;

  assign prod  = {{pnm_pkg::SCALE_W{1'b0}}, number} * {{pnm_pkg::NUM_W{1'b0}}, cfg.range_scale};
  assign whole = prod[PROD_W-1:16];

  always_comb begin
    if (cfg.wide_samples) begin
      sample = (|whole[PROD_W-17:16]) ? 16'hFFFF : whole[15:0];
    end else begin
      sample = (|whole[PROD_W-17:8]) ? 16'h00FF : {8'h00, whole[7:0]};
    end
  end

endmodule

// File: hdl/pnm_frame.sv
// Frame position tracking: channel, column and row counters with last-sample flag.
module pnm_frame (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  pnm_pkg::cfg_t cfg,
  output logic          last
);

  localparam int DB = pnm_pkg::DIMENSION_BITS;

  logic [pnm_pkg::CH_IDX_W-1:0] chan_r, chan_nxt;
  logic [DB-1:0]                col_r, col_nxt, row_r, row_nxt;
  logic [pnm_pkg::CH_W-1:0]     ch_lim;
  logic [DB-1:0]                w_lim, h_lim;
  logic                         ch_end, col_end, row_end;

  always_comb begin
    if (cfg.channel_count == '0) begin
      ch_lim = pnm_pkg::CH_W'(1);
    end else if (cfg.channel_count > pnm_pkg::CH_W'(4)) begin
      ch_lim = pnm_pkg::CH_W'(4);
    end else begin
      ch_lim = cfg.channel_count;
    end
    w_lim   = (cfg.frame_width == '0) ? DB'(1) : cfg.frame_width;
    h_lim   = (cfg.frame_height == '0) ? DB'(1) : cfg.frame_height;
    ch_end  = ({1'b0, chan_r} + 1'b1) >= ch_lim;
    col_end = ({1'b0, col_r} + 1'b1) >= {1'b0, w_lim};
    row_end = ({1'b0, row_r} + 1'b1) >= {1'b0, h_lim};
    last    = ch_end && col_end && row_end;

    chan_nxt = chan_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (!ch_end) begin
      chan_nxt = chan_r + 1'b1;
    end else begin
      chan_nxt = '0;
      if (!col_end) begin
        col_nxt = col_r + 1'b1;
      end else begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r <= '0;
      col_r  <= '0;
      row_r  <= '0;
    end else if (advance) begin
      chan_r <= chan_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
    end
  end

endmodule

// File: hdl/ascii_pnm_sample_parser.sv
// Top level of the ASCII PNM sample parser: ports, config registers, beat registers.
//
// Takes the raster text of an ASCII PNM image one byte per beat and returns one
// scaled sample per decimal word, flagging the last sample of each frame. A byte
// enters the input register, and once the result side can take it the scanner,
// the 20x32 scale multiply and the frame counters resolve it into the result
// register, which holds the sample of the word that byte closes. The block
// accepts one byte every clock as long as the result side keeps up; a waiting
// result holds only the one byte behind it. Errors (word not starting with a
// digit, word of seven or more characters) produce one result with the error
// status and then stop all further output until reset. Write the config
// registers only while the block is idle.
module ascii_pnm_sample_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  pnm_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output pnm_pkg::out_t                   out_data,
  input  logic                            cfg_we,
  input  logic [pnm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pnm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  pnm_pkg::cfg_t                 cfg_r;
  pnm_pkg::in_t                  in_r;
  logic                          in_vld_r, in_vld_nxt;
  pnm_pkg::out_t                 out_r, out_nxt;
  logic                          out_vld_r, out_vld_nxt;
  logic                          adv, in_take;
  pnm_pkg::close_evt_t           evt;
  logic [pnm_pkg::SAMPLE_W-1:0]  sample;
  logic                          last;
  logic                          emit_ok;

  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;
  assign in_take  = in_valid && in_ready;
  assign emit_ok  = evt.close && (evt.status == pnm_pkg::ST_OK);

  pnm_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .in_beat (in_r),
    .evt     (evt)
  );

  pnm_scale u_scale (
    .number (evt.number),
    .cfg    (cfg_r),
    .sample (sample)
  );

  pnm_frame u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (emit_ok),
    .cfg     (cfg_r),
    .last    (last)
  );

  always_comb begin
    in_vld_nxt = in_take ? 1'b1 : (adv ? 1'b0 : in_vld_r);
    out_vld_nxt = adv ? evt.close : (out_vld_r && !out_ready);
    out_nxt.parse_status = evt.status;
    out_nxt.sample_value = emit_ok ? sample : '0;
    out_nxt.frame_last   = emit_ok && last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width   <= pnm_pkg::DIMENSION_BITS'(1);
      cfg_r.frame_height  <= pnm_pkg::DIMENSION_BITS'(1);
      cfg_r.channel_count <= pnm_pkg::CH_W'(1);
      cfg_r.wide_samples  <= 1'b0;
      cfg_r.range_scale   <= pnm_pkg::SCALE_W'(65536);
    end else if (cfg_we) begin
      case (cfg_index)
        pnm_pkg::REG_FRAME_WIDTH:   cfg_r.frame_width   <= cfg_wdata[pnm_pkg::DIMENSION_BITS-1:0];
        pnm_pkg::REG_FRAME_HEIGHT:  cfg_r.frame_height  <= cfg_wdata[pnm_pkg::DIMENSION_BITS-1:0];
        pnm_pkg::REG_CHANNEL_COUNT: cfg_r.channel_count <= cfg_wdata[pnm_pkg::CH_W-1:0];
        pnm_pkg::REG_WIDE_SAMPLES:  cfg_r.wide_samples  <= cfg_wdata[0];
        pnm_pkg::REG_RANGE_SCALE:   cfg_r.range_scale   <= cfg_wdata[pnm_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
    if (adv && evt.close) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_err_beat_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_r.parse_status != pnm_pkg::ST_OK)) |->
      ((out_r.sample_value == '0) && !out_r.frame_last))
    else $error("error beat carries sample data");

  a_quiet_after_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_ready && (out_r.parse_status != pnm_pkg::ST_OK)) |=> !out_vld_r)
    else $error("result emitted after error beat");
`endif

endmodule
